### rtl/assert_macros.svh
// assertion macros shared by the rtl of the line follower steering block
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// whenever ante holds at a clock edge, cons must hold at the same edge
`define LFPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfps check failed");

// cond must never hold at a clock edge out of reset
`define LFPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lfps check failed");

`endif

### rtl/lfps_pkg.sv
// shared types, constants and codes for the line follower steering block
// no dependencies; used by every module of the block
package lfps_pkg;

    localparam int SENSOR_COUNT = 8;
    localparam int SENSOR_W     = 10;
    localparam int POS_W        = 13;
    localparam int ERR_W        = 13;
    localparam int GAIN_W       = 16;
    localparam int DUTY_W       = 8;
    localparam int DIR_W        = 2;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam int POS_SCALE    = 1000;
    localparam int IDX_SUM_MAX  = SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
    localparam int LIT_W        = $clog2(SENSOR_COUNT + 1);
    localparam int IDX_SUM_W    = $clog2(IDX_SUM_MAX + 1);
    localparam int NUM_W        = $clog2(IDX_SUM_MAX * POS_SCALE + 1);
    localparam int DIV_CNT_W    = $clog2(NUM_W);
    localparam int SAT_W        = (NUM_W > POS_W) ? NUM_W : POS_W;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [POS_W-1:0] CENTRE  = POS_W'(3500);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(8191);
    localparam int ERR_MAX = 4095;
    localparam int ERR_MIN = -4096;

    // motor direction codes
    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    // drive mode codes
    localparam logic [MODE_W-1:0] MODE_FOLLOW  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RECOVER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DARK    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_PAUSE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LOST_HIGH = 3'd7;

    typedef logic [SENSOR_COUNT-1:0][SENSOR_W-1:0] t_sensors;

    typedef struct packed {
        logic [SENSOR_W-1:0] threshold;
        logic [GAIN_W-1:0]   gain_p;
        logic [GAIN_W-1:0]   gain_d;
        logic [DUTY_W-1:0]   base_speed;
        logic [DUTY_W-1:0]   speed_limit;
        logic [DUTY_W-1:0]   spin_speed;
        logic [POS_W-1:0]    lost_low;
        logic [POS_W-1:0]    lost_high;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        threshold:   SENSOR_W'(1000),
        gain_p:      GAIN_W'(3277),
        gain_d:      GAIN_W'(1966),
        base_speed:  DUTY_W'(200),
        speed_limit: DUTY_W'(255),
        spin_speed:  DUTY_W'(160),
        lost_low:    POS_W'(1000),
        lost_high:   POS_W'(6500)
    };

    // classified sample handed from front to back
    typedef struct packed {
        logic             pause;
        logic [LIT_W-1:0] lit;
        logic [NUM_W-1:0] num;
    } t_item;

endpackage

### rtl/lfps_front.sv
// front end: accepts a sensor sample, thresholds it and forms lit count
// and scaled index sum; depends on lfps_pkg
module lfps_front (
    input  logic                           i_valid,
    input  lfps_pkg::t_sensors             i_sensors,
    input  logic                           i_pause,
    input  logic [lfps_pkg::SENSOR_W-1:0]  i_threshold,
    input  logic                           i_full,
    output logic                           o_stall,
    output logic                           o_push,
    output lfps_pkg::t_item                o_item
);

    logic [lfps_pkg::LIT_W-1:0]     w_cnt;
    logic [lfps_pkg::IDX_SUM_W-1:0] w_sum;

    always_comb begin
        w_cnt = '0;
        w_sum = '0;
        for (int i = 0; i < lfps_pkg::SENSOR_COUNT; i++) begin
            if (i_sensors[i] >= i_threshold) begin
                w_cnt = w_cnt + lfps_pkg::LIT_W'(1);
                w_sum = w_sum + lfps_pkg::IDX_SUM_W'(i);
            end
        end
    end

    assign o_item.pause = i_pause;
    assign o_item.lit   = w_cnt;
    assign o_item.num   = lfps_pkg::NUM_W'(w_sum) * lfps_pkg::NUM_W'(lfps_pkg::POS_SCALE);

    assign o_stall = i_full;
    assign o_push  = i_valid & ~i_full;

endmodule

### rtl/lfps_queue.sv
// short fifo of classified samples between front and back
// depends on lfps_pkg
module lfps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lfps_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output lfps_pkg::t_item o_item
);

    localparam int PTR_W = $clog2(lfps_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lfps_pkg::QUEUE_DEPTH + 1);

    lfps_pkg::t_item  r_mem [lfps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(lfps_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(lfps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(lfps_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/lfps_back.sv
// back end: divides for the line position, picks the drive mode, runs
// the pd steering and holds the output register; depends on lfps_pkg
module lfps_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_valid,
    input  lfps_pkg::t_item                      i_q_item,
    output logic                                 o_pop,
    input  lfps_pkg::t_cfg                       i_cfg,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [lfps_pkg::DIR_W-1:0]           o_left_direction,
    output logic [lfps_pkg::DIR_W-1:0]           o_right_direction,
    output logic [lfps_pkg::DUTY_W-1:0]          o_left_duty,
    output logic [lfps_pkg::DUTY_W-1:0]          o_right_duty,
    output logic [lfps_pkg::POS_W-1:0]           o_line_position,
    output logic [lfps_pkg::MODE_W-1:0]          o_drive_mode
);

    localparam int NUM_W = lfps_pkg::NUM_W;
    localparam int LIT_W = lfps_pkg::LIT_W;
    localparam int POS_W = lfps_pkg::POS_W;
    localparam int ERR_W = lfps_pkg::ERR_W;
    localparam int PP_W  = lfps_pkg::GAIN_W + 1 + ERR_W;
    localparam int PD_W  = lfps_pkg::GAIN_W + 2 + ERR_W;
    localparam int SUM_W = PD_W + 1;
    localparam int ADJ_W = SUM_W - lfps_pkg::GAIN_W;
    localparam int CL_W  = ADJ_W + 2;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SUM    = 3'd4;
    localparam logic [2:0] ST_CLAMP  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] r_state, n_state;

    // sample and divider
    logic                              r_pause;
    logic [LIT_W-1:0]                  r_lit;
    logic [NUM_W-1:0]                  r_div;
    logic [LIT_W-1:0]                  r_rem;
    logic [lfps_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [POS_W-1:0]                  r_newpos;

    // pd datapath
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ERR_W:0]     r_deriv;
    logic signed [PP_W-1:0]    r_prod_p;
    logic signed [PD_W-1:0]    r_prod_d;
    logic signed [ADJ_W-1:0]   r_adj;

    // block state
    logic [POS_W-1:0]          r_held;
    logic signed [ERR_W-1:0]   r_prev;

    // staged result and output register
    logic [lfps_pkg::DIR_W-1:0]  r_res_ldir, r_res_rdir;
    logic [lfps_pkg::DUTY_W-1:0] r_res_lduty, r_res_rduty;
    logic [POS_W-1:0]            r_res_pos;
    logic [lfps_pkg::MODE_W-1:0] r_res_mode;
    logic                        r_out_valid;
    logic [lfps_pkg::DIR_W-1:0]  r_out_ldir, r_out_rdir;
    logic [lfps_pkg::DUTY_W-1:0] r_out_lduty, r_out_rduty;
    logic [POS_W-1:0]            r_out_pos;
    logic [lfps_pkg::MODE_W-1:0] r_out_mode;

    logic [LIT_W:0]                  w_rem_sh;
    logic                            w_ge;
    logic [LIT_W:0]                  w_rem_sub;
    logic [NUM_W-1:0]                w_quo;
    logic [POS_W-1:0]                w_quo_sat;
    logic signed [POS_W:0]           w_diff;
    logic signed [ERR_W-1:0]         w_err;
    logic signed [SUM_W-1:0]         w_sum;
    logic signed [SUM_W-1:0]         w_sum_bias;
    logic signed [CL_W-1:0]          w_left, w_right;
    logic [lfps_pkg::DUTY_W-1:0]     w_lduty, w_rduty;
    logic                            w_recover;
    logic                            w_load;

    // one quotient bit per cycle
    assign w_rem_sh  = {r_rem, r_div[NUM_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_lit});
    assign w_rem_sub = w_rem_sh - {1'b0, r_lit};
    assign w_quo     = {r_div[NUM_W-2:0], w_ge};
    assign w_quo_sat = (lfps_pkg::SAT_W'(w_quo) > lfps_pkg::SAT_W'(lfps_pkg::POS_MAX)) ?
                       lfps_pkg::POS_MAX : POS_W'(w_quo);

    // error saturated to the signed error range
    assign w_diff = $signed({1'b0, r_newpos}) - $signed({1'b0, lfps_pkg::CENTRE});
    always_comb begin
        if (w_diff > $signed((POS_W+1)'(lfps_pkg::ERR_MAX))) begin
            w_err = ERR_W'(lfps_pkg::ERR_MAX);
        end else if (w_diff < $signed((POS_W+1)'(lfps_pkg::ERR_MIN))) begin
            w_err = ERR_W'(lfps_pkg::ERR_MIN);
        end else begin
            w_err = w_diff[ERR_W-1:0];
        end
    end

    // q16 sum, shift truncating toward zero
    assign w_sum      = r_prod_p + r_prod_d;
    assign w_sum_bias = w_sum[SUM_W-1] ? (w_sum + $signed(SUM_W'(16'hFFFF))) : w_sum;

    assign w_left  = $signed({{(CL_W-lfps_pkg::DUTY_W){1'b0}}, i_cfg.base_speed}) + r_adj;
    assign w_right = $signed({{(CL_W-lfps_pkg::DUTY_W){1'b0}}, i_cfg.base_speed}) - r_adj;

    always_comb begin
        if (w_left[CL_W-1]) begin
            w_lduty = '0;
        end else if (w_left > $signed({{(CL_W-lfps_pkg::DUTY_W){1'b0}}, i_cfg.speed_limit})) begin
            w_lduty = i_cfg.speed_limit;
        end else begin
            w_lduty = w_left[lfps_pkg::DUTY_W-1:0];
        end
        if (w_right[CL_W-1]) begin
            w_rduty = '0;
        end else if (w_right > $signed({{(CL_W-lfps_pkg::DUTY_W){1'b0}}, i_cfg.speed_limit})) begin
            w_rduty = i_cfg.speed_limit;
        end else begin
            w_rduty = w_right[lfps_pkg::DUTY_W-1:0];
        end
    end

    assign w_recover = (r_held >= i_cfg.lost_high) || (r_held <= i_cfg.lost_low);
    assign w_load    = (r_state == ST_OUT) && (!r_out_valid || !i_stall);
    assign o_pop     = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_q_item.pause || i_q_item.lit == '0) ? ST_DECIDE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = (r_pause || w_recover || r_lit == '0) ? ST_OUT : ST_MUL;
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_OUT;
            ST_OUT: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held      <= lfps_pkg::CENTRE;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DECIDE && !r_pause && w_recover) begin
                r_held <= r_newpos;
            end
            if (r_state == ST_CLAMP) begin
                r_held <= r_newpos;
                r_prev <= r_err;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_pause  <= i_q_item.pause;
                r_lit    <= i_q_item.lit;
                r_div    <= i_q_item.num;
                r_rem    <= '0;
                r_cnt    <= lfps_pkg::DIV_CNT_W'(NUM_W - 1);
                r_newpos <= r_held;
            end
            ST_DIV: begin
                r_rem <= w_ge ? w_rem_sub[LIT_W-1:0] : w_rem_sh[LIT_W-1:0];
                r_div <= w_quo;
                r_cnt <= r_cnt - lfps_pkg::DIV_CNT_W'(1);
                if (r_cnt == '0) begin
                    r_newpos <= w_quo_sat;
                end
            end
            ST_DECIDE: begin
                r_err       <= w_err;
                r_deriv     <= $signed({w_err[ERR_W-1], w_err}) - $signed({r_prev[ERR_W-1], r_prev});
                r_res_lduty <= i_cfg.spin_speed;
                r_res_rduty <= i_cfg.spin_speed;
                if (r_pause) begin
                    r_res_ldir  <= lfps_pkg::DIR_OFF;
                    r_res_rdir  <= lfps_pkg::DIR_OFF;
                    r_res_lduty <= '0;
                    r_res_rduty <= '0;
                    r_res_pos   <= r_held;
                    r_res_mode  <= lfps_pkg::MODE_PAUSE;
                end else if (w_recover) begin
                    // spin back toward the side the line was lost on
                    r_res_ldir <= (r_held >= i_cfg.lost_high) ? lfps_pkg::DIR_FWD
                                                              : lfps_pkg::DIR_REV;
                    r_res_rdir <= (r_held >= i_cfg.lost_high) ? lfps_pkg::DIR_REV
                                                              : lfps_pkg::DIR_FWD;
                    r_res_pos  <= r_newpos;
                    r_res_mode <= lfps_pkg::MODE_RECOVER;
                end else begin
                    r_res_ldir <= (r_held < lfps_pkg::CENTRE) ? lfps_pkg::DIR_REV
                                                              : lfps_pkg::DIR_FWD;
                    r_res_rdir <= (r_held < lfps_pkg::CENTRE) ? lfps_pkg::DIR_FWD
                                                              : lfps_pkg::DIR_REV;
                    r_res_pos  <= r_held;
                    r_res_mode <= lfps_pkg::MODE_DARK;
                end
            end
            ST_MUL: begin
                r_prod_p <= $signed({1'b0, i_cfg.gain_p}) * r_err;
                r_prod_d <= $signed({1'b0, i_cfg.gain_d}) * r_deriv;
            end
            ST_SUM: begin
                r_adj <= w_sum_bias[SUM_W-1:lfps_pkg::GAIN_W];
            end
            ST_CLAMP: begin
                r_res_ldir  <= lfps_pkg::DIR_FWD;
                r_res_rdir  <= lfps_pkg::DIR_FWD;
                r_res_lduty <= w_lduty;
                r_res_rduty <= w_rduty;
                r_res_pos   <= r_newpos;
                r_res_mode  <= lfps_pkg::MODE_FOLLOW;
            end
            ST_OUT: begin
                if (w_load) begin
                    r_out_ldir  <= r_res_ldir;
                    r_out_rdir  <= r_res_rdir;
                    r_out_lduty <= r_res_lduty;
                    r_out_rduty <= r_res_rduty;
                    r_out_pos   <= r_res_pos;
                    r_out_mode  <= r_res_mode;
                end
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_left_direction  = r_out_ldir;
    assign o_right_direction = r_out_rdir;
    assign o_left_duty       = r_out_lduty;
    assign o_right_duty      = r_out_rduty;
    assign o_line_position   = r_out_pos;
    assign o_drive_mode      = r_out_mode;

endmodule

### rtl/line_follower_pd_steering.sv
// top level of the line follower pd steering block: config registers,
// front, queue and back; depends on lfps_pkg and assert_macros.svh
//
// usage
// - input channel (i_in_valid / o_in_stall): one item is eight sensor
//   readings plus a pause request, taken when valid is high and stall low
// - output channel (o_out_valid / i_out_stall): one motor command per item,
//   held unchanged while the receiver stalls
// - config channel (i_cfg_valid / o_cfg_ready): index and data, always ready;
//   write only while no item is in flight
// - the front thresholds and sums combinationally into a two-entry queue,
//   so it keeps taking items while the back is busy or the output waits,
//   until the queue is full
// - back steps: following mode runs the serial divider, one quotient bit at
//   a time, then decide, multiply, sum, clamp and load; pause and all-dark
//   items run decide and load only, edge recovery with lit sensors adds the
//   divider; the back takes no new item until the last one is loaded
// - reset (synchronous, active low) restores register defaults, centre
//   position and zero previous error, and empties queue and output
// - a stalled output holds the back in its load state; the queue then fills
//   and o_in_stall rises
`include "assert_macros.svh"

module line_follower_pd_steering (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // sensor item
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_0,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_1,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_2,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_3,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_4,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_5,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_6,
    input  logic [lfps_pkg::SENSOR_W-1:0]         i_sensor_7,
    input  logic                                  i_pause_request,
    // motor command item
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [lfps_pkg::DIR_W-1:0]            o_left_direction,
    output logic [lfps_pkg::DIR_W-1:0]            o_right_direction,
    output logic [lfps_pkg::DUTY_W-1:0]           o_left_duty,
    output logic [lfps_pkg::DUTY_W-1:0]           o_right_duty,
    output logic [lfps_pkg::POS_W-1:0]            o_line_position,
    output logic [lfps_pkg::MODE_W-1:0]           o_drive_mode,
    // config writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [lfps_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    lfps_pkg::t_cfg     r_cfg;
    lfps_pkg::t_sensors w_sensors;
    lfps_pkg::t_item    w_front_item;
    lfps_pkg::t_item    w_q_item;
    logic               w_push;
    logic               w_full;
    logic               w_q_valid;
    logic               w_pop;

    assign o_cfg_ready = 1'b1;

    // config register file, fields truncated to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lfps_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lfps_pkg::CFG_THRESHOLD: r_cfg.threshold   <= i_cfg_data[lfps_pkg::SENSOR_W-1:0];
                lfps_pkg::CFG_GAIN_P:    r_cfg.gain_p      <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::CFG_GAIN_D:    r_cfg.gain_d      <= i_cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::CFG_BASE:      r_cfg.base_speed  <= i_cfg_data[lfps_pkg::DUTY_W-1:0];
                lfps_pkg::CFG_LIMIT:     r_cfg.speed_limit <= i_cfg_data[lfps_pkg::DUTY_W-1:0];
                lfps_pkg::CFG_SPIN:      r_cfg.spin_speed  <= i_cfg_data[lfps_pkg::DUTY_W-1:0];
                lfps_pkg::CFG_LOST_LOW:  r_cfg.lost_low    <= i_cfg_data[lfps_pkg::POS_W-1:0];
                lfps_pkg::CFG_LOST_HIGH: r_cfg.lost_high   <= i_cfg_data[lfps_pkg::POS_W-1:0];
            endcase
        end
    end

    // sensor 0 is leftmost and carries index 0
    assign w_sensors[0] = i_sensor_0;
    assign w_sensors[1] = i_sensor_1;
    assign w_sensors[2] = i_sensor_2;
    assign w_sensors[3] = i_sensor_3;
    assign w_sensors[4] = i_sensor_4;
    assign w_sensors[5] = i_sensor_5;
    assign w_sensors[6] = i_sensor_6;
    assign w_sensors[7] = i_sensor_7;

    lfps_front u_front (
        .i_valid     (i_in_valid),
        .i_sensors   (w_sensors),
        .i_pause     (i_pause_request),
        .i_threshold (r_cfg.threshold),
        .i_full      (w_full),
        .o_stall     (o_in_stall),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    lfps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    lfps_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (w_q_valid),
        .i_q_item          (w_q_item),
        .o_pop             (w_pop),
        .i_cfg             (r_cfg),
        .o_valid           (o_out_valid),
        .i_stall           (i_out_stall),
        .o_left_direction  (o_left_direction),
        .o_right_direction (o_right_direction),
        .o_left_duty       (o_left_duty),
        .o_right_duty      (o_right_duty),
        .o_line_position   (o_line_position),
        .o_drive_mode      (o_drive_mode)
    );

    // following drives both motors forward within the speed limit
    `LFPS_ASSERT_IMPL(a_follow_fwd, i_clk, i_rst_n,
        o_out_valid && o_drive_mode == lfps_pkg::MODE_FOLLOW,
        o_left_direction == lfps_pkg::DIR_FWD && o_right_direction == lfps_pkg::DIR_FWD &&
        o_left_duty <= r_cfg.speed_limit && o_right_duty <= r_cfg.speed_limit)

    // pause stops both motors
    `LFPS_ASSERT_IMPL(a_pause_off, i_clk, i_rst_n,
        o_out_valid && o_drive_mode == lfps_pkg::MODE_PAUSE,
        o_left_direction == lfps_pkg::DIR_OFF && o_right_direction == lfps_pkg::DIR_OFF &&
        o_left_duty == '0 && o_right_duty == '0)

    // spin modes turn the motors in opposite directions at spin speed
    `LFPS_ASSERT_IMPL(a_spin_opposite, i_clk, i_rst_n,
        o_out_valid && (o_drive_mode == lfps_pkg::MODE_RECOVER ||
                        o_drive_mode == lfps_pkg::MODE_DARK),
        o_left_direction != o_right_direction && o_left_direction != lfps_pkg::DIR_OFF &&
        o_right_direction != lfps_pkg::DIR_OFF && o_left_duty == r_cfg.spin_speed &&
        o_right_duty == r_cfg.spin_speed)

    // the queue never takes an item while it is full
    `LFPS_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_full)

endmodule
